/* src/ptds_pkg.sv */
// Package for the periodic task due scheduler.
// Holds shared constants, request and status codes, and the arithmetic unit interface types.
// No dependencies.
package ptds_pkg;

    localparam int NUM_TASKS_DEF = 4;
    localparam int MAX_TASKS     = 4;
    localparam int TIME_W        = 63;
    localparam int MASK_W        = 4;
    localparam int CFG_IDX_W     = 3;

    localparam logic [TIME_W-1:0] NS_PER_SEC = 63'd1000000000;

    localparam logic [1:0] REQ_PEEK     = 2'd0;
    localparam logic [1:0] REQ_COMPLETE = 2'd1;
    localparam logic [1:0] REQ_RESTART  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADCFG = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING0 = 3'd2;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_alu_rsp;

endpackage

/* src/ptds_alu.sv */
// Iterative arithmetic unit: one bit per cycle shift-add multiply with overflow detection
// past the signed 64-bit range, and restoring divide of 64 bits by 32 bits.
// Depends on ptds_pkg.
module ptds_alu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptds_pkg::t_alu_req        i_req,
    input  logic [63:0]               i_a,
    input  logic [ptds_pkg::TIME_W-1:0] i_b,
    output ptds_pkg::t_alu_rsp        o_rsp,
    output logic [63:0]               o_q,
    output logic [63:0]               o_acc
);

    logic                        r_busy;
    logic                        r_done;
    logic                        r_ovf;
    logic [6:0]                  r_cnt;
    ptds_pkg::t_alu_op           r_op;
    logic [63:0]                 r_a;
    logic [63:0]                 r_acc;
    logic [ptds_pkg::TIME_W-1:0] r_b;

    logic [63:0] n_addend;
    logic [64:0] n_sum;
    logic [32:0] n_part;
    logic [33:0] n_diff;
    logic        n_ge;

    always_comb begin
        n_addend = r_a[63] ? {1'b0, r_b} : 64'd0;
        n_sum    = {r_acc, 1'b0} + {1'b0, n_addend};
        n_part   = {r_acc[31:0], r_a[63]};
        n_diff   = {1'b0, n_part} - {2'b00, r_b[31:0]};
        n_ge     = !n_diff[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= 7'd0;
            r_op   <= ptds_pkg::ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ovf  <= 1'b0;
                r_cnt  <= 7'd64;
                r_op   <= i_req.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= 64'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                case (r_op)
                    ptds_pkg::ALU_MUL: begin
                        r_acc <= n_sum[63:0];
                        r_a   <= {r_a[62:0], 1'b0};
                        if (n_sum[64:63] != 2'b00) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    ptds_pkg::ALU_DIV: begin
                        r_acc <= {32'd0, n_ge ? n_diff[31:0] : n_part[31:0]};
                        r_a   <= {r_a[62:0], n_ge};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_q        = r_a;
    assign o_acc      = r_acc;

endmodule

/* src/periodic_task_due_scheduler_core.sv */
// Periodic task due scheduler, top level.
// Sequencer, task state and result register around the shared iterative unit ptds_alu.
// Depends on ptds_pkg and ptds_alu.

// In a peek, one stored due time is compared per cycle.
// Restart and complete also reschedule each affected task through the single shared
// multiply/divide unit, which handles one bit per cycle: a task timed by a period takes one
// multiply, a task timed by a rate takes a divide, two multiplies and a divide. The input is
// not ready while a beat is in work; a finished result waits in the output register while
// the next beat is taken.
module periodic_task_due_scheduler_core #(
    parameter int NUM_TASKS = ptds_pkg::NUM_TASKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ptds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptds_pkg::TIME_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] compare time
    input  logic [63:0]                     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] status, [2] due_now, [65:3] batch_time, [69:66] batch_mask
    output logic [71:0]                     m_axis_tdata
);

    localparam int NT = (NUM_TASKS > ptds_pkg::MAX_TASKS) ? ptds_pkg::MAX_TASKS : NUM_TASKS;
    localparam int TW = (NT > 1) ? $clog2(NT) : 1;
    localparam int KW = $clog2(NT + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TASK,
        S_DIV_SEC,
        S_MUL_SEC,
        S_MUL_REM,
        S_DIV_FRAC,
        S_MUL_PER,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [ptds_pkg::MASK_W-1:0] r_enable;
    logic [ptds_pkg::MASK_W-1:0] r_rate;
    logic [ptds_pkg::TIME_W-1:0] r_timing [NT];
    logic [63:0]                 r_tick   [NT];
    logic [ptds_pkg::TIME_W-1:0] r_due    [NT];
    logic [NT-1:0]               r_sched;

    logic                        r_cmpl;
    logic [63:0]                 r_target;
    logic [KW-1:0]               r_k;
    logic [NT-1:0]               r_sel;
    logic [ptds_pkg::TIME_W-1:0] r_bt;
    logic [NT-1:0]               r_bm;
    logic                        r_any;
    logic                        r_dn;
    logic                        r_bad;
    logic                        r_ovf;
    logic                        r_empty;
    logic [31:0]                 r_rem;
    logic [ptds_pkg::TIME_W-1:0] r_p;

    logic                        r_mv;
    logic [1:0]                  r_status;
    logic                        r_due_now;
    logic [ptds_pkg::TIME_W-1:0] r_out_bt;
    logic [NT-1:0]               r_out_bm;

    ptds_pkg::t_alu_req          r_alu_req;
    logic [63:0]                 r_alu_a;
    logic [ptds_pkg::TIME_W-1:0] r_alu_b;
    ptds_pkg::t_alu_rsp          alu_rsp;
    logic [63:0]                 alu_q;
    logic [63:0]                 alu_acc;

    logic [TW-1:0]               idx;
    logic [NT-1:0]               n_valid;
    logic                        n_bad_any;
    logic                        n_accept;
    logic [63:0]                 n_tick;
    logic [63:0]                 n_sum;
    logic [NT-1:0]               n_bit;
    logic [1:0]                  n_status;

    ptds_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_alu_req),
        .i_a     (r_alu_a),
        .i_b     (r_alu_b),
        .o_rsp   (alu_rsp),
        .o_q     (alu_q),
        .o_acc   (alu_acc)
    );

    always_comb begin
        idx       = r_k[TW-1:0];
        n_accept  = s_axis_tvalid && s_axis_tready;
        n_bad_any = 1'b0;
        for (int j = 0; j < NT; j++) begin
            n_valid[j] = (r_timing[j] != '0) && !(r_rate[j] && (r_timing[j][62:32] != '0));
            if (r_enable[j] && !n_valid[j]) begin
                n_bad_any = 1'b1;
            end
        end
        n_tick   = r_tick[idx] + (r_cmpl ? 64'd2 : 64'd1);
        n_sum    = {1'b0, r_p} + alu_q;
        n_bit    = NT'(1) << idx;
        if (r_empty) begin
            n_status = ptds_pkg::ST_EMPTY;
        end else if (r_bad) begin
            n_status = ptds_pkg::ST_BADCFG;
        end else if (r_ovf) begin
            n_status = ptds_pkg::ST_OVF;
        end else begin
            n_status = ptds_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_enable        <= '0;
            r_rate          <= '0;
            r_sched         <= '0;
            r_mv            <= 1'b0;
            r_alu_req.start <= 1'b0;
            r_alu_req.op    <= ptds_pkg::ALU_MUL;
            for (int j = 0; j < NT; j++) begin
                r_timing[j] <= '0;
                r_tick[j]   <= '0;
                r_due[j]    <= '0;
            end
        end else begin
            r_alu_req.start <= 1'b0;

            if (i_cfg_we) begin
                if (i_cfg_idx == ptds_pkg::CFG_ENABLE) begin
                    r_enable <= i_cfg_data[ptds_pkg::MASK_W-1:0];
                end else if (i_cfg_idx == ptds_pkg::CFG_RATE) begin
                    r_rate <= i_cfg_data[ptds_pkg::MASK_W-1:0];
                end
                for (int j = 0; j < NT; j++) begin
                    if (i_cfg_idx == ptds_pkg::CFG_IDX_W'(int'(ptds_pkg::CFG_TIMING0) + j)) begin
                        r_timing[j] <= i_cfg_data;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                r_mv <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_cmpl   <= (s_axis_tuser == ptds_pkg::REQ_COMPLETE);
                        r_target <= s_axis_tdata;
                        r_k      <= '0;
                        r_bt     <= '0;
                        r_bm     <= '0;
                        r_any    <= 1'b0;
                        r_dn     <= 1'b0;
                        r_bad    <= 1'b0;
                        r_ovf    <= 1'b0;
                        r_empty  <= 1'b0;
                        if (s_axis_tuser == ptds_pkg::REQ_RESTART) begin
                            r_sched <= '0;
                            r_sel   <= r_enable[NT-1:0];
                            for (int j = 0; j < NT; j++) begin
                                r_tick[j] <= '0;
                            end
                            if (n_bad_any) begin
                                r_bad   <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_TASK;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_k == KW'(NT)) begin
                        r_k <= '0;
                        if (!r_any) begin
                            r_empty <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_dn <= ($signed({1'b0, r_bt}) <= $signed(r_target));
                            if (r_cmpl) begin
                                r_sel   <= r_bm;
                                r_state <= S_TASK;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        r_k <= r_k + KW'(1);
                        if (r_sched[idx]) begin
                            if (!r_any || (r_due[idx] < r_bt)) begin
                                r_bt  <= r_due[idx];
                                r_bm  <= n_bit;
                                r_any <= 1'b1;
                            end else if (r_due[idx] == r_bt) begin
                                r_bm <= r_bm | n_bit;
                            end
                        end
                    end
                end
                S_TASK: begin
                    if (r_k == KW'(NT)) begin
                        r_state <= S_DONE;
                    end else if (!r_sel[idx]) begin
                        r_k <= r_k + KW'(1);
                    end else begin
                        r_sched[idx] <= 1'b0;
                        if (r_cmpl) begin
                            r_tick[idx] <= r_tick[idx] + 64'd1;
                        end
                        if (!n_valid[idx]) begin
                            r_bad <= 1'b1;
                            r_k   <= r_k + KW'(1);
                        end else begin
                            r_alu_req.start <= 1'b1;
                            r_alu_a         <= n_tick;
                            r_alu_b         <= r_timing[idx];
                            if (r_rate[idx]) begin
                                r_alu_req.op <= ptds_pkg::ALU_DIV;
                                r_state      <= S_DIV_SEC;
                            end else begin
                                r_alu_req.op <= ptds_pkg::ALU_MUL;
                                r_state      <= S_MUL_PER;
                            end
                        end
                    end
                end
                S_DIV_SEC: begin
                    if (alu_rsp.done) begin
                        r_rem           <= alu_acc[31:0];
                        r_alu_req.start <= 1'b1;
                        r_alu_req.op    <= ptds_pkg::ALU_MUL;
                        r_alu_a         <= alu_q;
                        r_alu_b         <= ptds_pkg::NS_PER_SEC;
                        r_state         <= S_MUL_SEC;
                    end
                end
                S_MUL_SEC: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.ovf) begin
                            r_ovf   <= 1'b1;
                            r_k     <= r_k + KW'(1);
                            r_state <= S_TASK;
                        end else begin
                            r_p             <= alu_acc[ptds_pkg::TIME_W-1:0];
                            r_alu_req.start <= 1'b1;
                            r_alu_req.op    <= ptds_pkg::ALU_MUL;
                            r_alu_a         <= {32'd0, r_rem};
                            r_alu_b         <= ptds_pkg::NS_PER_SEC;
                            r_state         <= S_MUL_REM;
                        end
                    end
                end
                S_MUL_REM: begin
                    if (alu_rsp.done) begin
                        r_alu_req.start <= 1'b1;
                        r_alu_req.op    <= ptds_pkg::ALU_DIV;
                        r_alu_a         <= alu_acc;
                        r_alu_b         <= r_timing[idx];
                        r_state         <= S_DIV_FRAC;
                    end
                end
                S_DIV_FRAC: begin
                    if (alu_rsp.done) begin
                        if (n_sum[63]) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_due[idx]   <= n_sum[ptds_pkg::TIME_W-1:0];
                            r_sched[idx] <= 1'b1;
                        end
                        r_k     <= r_k + KW'(1);
                        r_state <= S_TASK;
                    end
                end
                S_MUL_PER: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.ovf) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_due[idx]   <= alu_acc[ptds_pkg::TIME_W-1:0];
                            r_sched[idx] <= 1'b1;
                        end
                        r_k     <= r_k + KW'(1);
                        r_state <= S_TASK;
                    end
                end
                S_DONE: begin
                    if (!r_mv || m_axis_tready) begin
                        r_mv      <= 1'b1;
                        r_status  <= n_status;
                        r_due_now <= r_dn;
                        r_out_bt  <= r_bt;
                        r_out_bm  <= r_bm;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {2'b00, ptds_pkg::MASK_W'(r_out_bm), r_out_bt, r_due_now, r_status};

    a_sched_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !n_accept) |=> $stable(r_sched))
        else $error("schedule changed while idle");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_DIV_SEC || r_state == S_MUL_SEC ||
                          r_state == S_MUL_REM || r_state == S_DIV_FRAC ||
                          r_state == S_MUL_PER))
        else $error("arithmetic result arrived with no operation pending");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == ptds_pkg::ST_EMPTY) |-> (r_out_bm == '0 && r_out_bt == '0))
        else $error("empty result carries a batch");

endmodule

/* bench/testbench.sv */
// Self-checking bench for periodic_task_due_scheduler_core: directed table, then random beats.
// A schedule predictor checks every result beat; both sides stall at random until the last third.
// Depends on ptds_pkg and the scheduler RTL.
module testbench;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [ptds_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [ptds_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [62:0] TIME_TOP = {63{1'b1}};
    localparam logic [63:0] RATE_TOP = 64'hFFFF_FFFF;
    localparam int RANDOM_BEATS = 1900;

    typedef struct packed {
        logic [1:0]  status;
        logic        due_now;
        logic [62:0] when;
        logic [3:0]  mask;
    } t_result;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  code;
        logic [63:0] data;
        bit          typed;
        t_result     want;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ptds_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ptds_pkg::TIME_W-1:0]    i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata = '0;
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [71:0]                    m_axis_tdata;

    periodic_task_due_scheduler_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the schedule.
    logic [3:0]  sh_enable;
    logic [3:0]  sh_rate;
    logic [62:0] sh_timing [4];
    logic [63:0] sh_ticks [4];
    logic [62:0] sh_due [4];
    bit          sh_sched [4];

    t_result pending_q[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      mismatches;

    function automatic bit timing_ok(int k);
        if (sh_timing[k] == '0) return 0;
        if (sh_rate[k] && {1'b0, sh_timing[k]} > RATE_TOP) return 0;
        return 1;
    endfunction

    function automatic bit tick_due(int k, logic [63:0] n, output logic [62:0] t);
        logic [63:0] v, sec, rem, total;
        v = {1'b0, sh_timing[k]};
        t = '0;
        if (sh_rate[k]) begin
            sec = n / v;
            rem = n % v;
            if (sec > {1'b0, TIME_TOP} / 64'd1000000000) return 0;
            total = sec * 64'd1000000000 + (rem * 64'd1000000000) / v;
            if (total > {1'b0, TIME_TOP}) return 0;
            t = total[62:0];
            return 1;
        end
        if (n > {1'b0, TIME_TOP} / v) return 0;
        total = n * v;
        t = total[62:0];
        return 1;
    endfunction

    function automatic logic [1:0] reschedule(int k);
        logic [62:0] t;
        sh_sched[k] = 0;
        if (!timing_ok(k)) return ptds_pkg::ST_BADCFG;
        if (!tick_due(k, sh_ticks[k] + 64'd1, t)) return ptds_pkg::ST_OVF;
        sh_due[k] = t;
        sh_sched[k] = 1;
        return ptds_pkg::ST_OK;
    endfunction

    function automatic bit next_batch(output logic [62:0] t, output logic [3:0] m);
        bit any;
        any = 0;
        t = '0;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (!sh_sched[k]) continue;
            if (!any || sh_due[k] < t) begin
                t = sh_due[k];
                m = '0;
                any = 1;
            end
            if (sh_due[k] == t) m[k] = 1'b1;
        end
        return any;
    endfunction

    function automatic t_result schedule_step(logic [1:0] req, logic [63:0] target);
        t_result r;
        bit bad, badcfg, ovf;
        logic [1:0] s;
        r = '0;
        r.status = ptds_pkg::ST_OK;
        if (req == ptds_pkg::REQ_RESTART) begin
            bad = 0;
            for (int k = 0; k < 4; k++) begin
                sh_ticks[k] = '0;
                sh_sched[k] = 0;
                if (sh_enable[k] && !timing_ok(k)) bad = 1;
            end
            if (bad) r.status = ptds_pkg::ST_BADCFG;
            else
                for (int k = 0; k < 4; k++)
                    if (sh_enable[k] && reschedule(k) == ptds_pkg::ST_OVF)
                        r.status = ptds_pkg::ST_OVF;
        end else if (!next_batch(r.when, r.mask)) begin
            r.status = ptds_pkg::ST_EMPTY;
        end else begin
            r.due_now = $signed({1'b0, r.when}) <= $signed(target);
            if (req == ptds_pkg::REQ_COMPLETE) begin
                badcfg = 0;
                ovf = 0;
                for (int k = 0; k < 4; k++) begin
                    if (!r.mask[k]) continue;
                    sh_ticks[k] = sh_ticks[k] + 64'd1;
                    s = reschedule(k);
                    if (s == ptds_pkg::ST_BADCFG) badcfg = 1;
                    else if (s == ptds_pkg::ST_OVF) ovf = 1;
                end
                r.status = badcfg ? ptds_pkg::ST_BADCFG :
                           (ovf ? ptds_pkg::ST_OVF : ptds_pkg::ST_OK);
            end
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[62:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ptds_pkg::CFG_ENABLE) sh_enable = value[3:0];
        else if (idx == ptds_pkg::CFG_RATE) sh_rate = value[3:0];
        else if (idx >= ptds_pkg::CFG_TIMING0 && idx < CFG_SPARE_LO)
            sh_timing[idx - ptds_pkg::CFG_TIMING0] = value[62:0];
        @(posedge i_clk);
    endtask

    // Returns the prediction for the accepted beat.
    task automatic send_beat(logic [1:0] req, logic [63:0] target, output t_result r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= target;
        do @(posedge i_clk); while (!s_axis_tready);
        r = schedule_step(req, target);
        pending_q = {pending_q, r};
    endtask

    task automatic check_beat(logic [71:0] d);
        t_result got, want;
        got = {d[1:0], d[2], d[65:3], d[69:66]};
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", d);
        end else begin
            want = pending_q.pop_front();
            if (got.status !== want.status || got.due_now !== want.due_now ||
                got.when !== want.when || got.mask !== want.mask) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st=%0d due=%0d t=%0d m=%h, ",
                              "got st=%0d due=%0d t=%0d m=%h"},
                             want.status, want.due_now, want.when, want.mask,
                             got.status, got.due_now, got.when, got.mask);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] pick_timing();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return {1'b0, TIME_TOP};
            2: return {$urandom, $urandom} >> 1;
            3: return RATE_TOP;
            4: return RATE_TOP + 64'd1;
            5, 6: return 64'($urandom_range(40, 1));
            default: return 64'($urandom_range(3000, 1));
        endcase
    endfunction

    function automatic logic [63:0] pick_target();
        logic [62:0] t;
        logic [3:0] m;
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            default: begin
                void'(next_batch(t, m));
                return {1'b0, t} + 64'($signed($urandom_range(4)) - 2);
            end
        endcase
    endfunction

    function automatic logic [1:0] pick_request();
        int p;
        p = $urandom_range(99);
        if (p < 8) return ptds_pkg::REQ_RESTART;
        if (p < 55) return ptds_pkg::REQ_COMPLETE;
        if (p < 95) return ptds_pkg::REQ_PEEK;
        return REQ_UNKNOWN;
    endfunction

    t_row rows[$];

    function automatic t_row beat_row(logic [1:0] req, logic [63:0] target);
        t_row w;
        w.kind = ROW_BEAT; w.code = {1'b0, req}; w.data = target; w.typed = 0; w.want = '0;
        return w;
    endfunction

    function automatic t_row typed_row(logic [1:0] req, logic [63:0] target, logic [1:0] st);
        t_row w;
        w = beat_row(req, target);
        w.typed = 1;
        w.want.status = st;
        return w;
    endfunction

    function automatic t_row cfg_row(logic [2:0] idx, logic [63:0] value);
        t_row w;
        w.kind = ROW_CFG; w.code = idx; w.data = value; w.typed = 0; w.want = '0;
        return w;
    endfunction

    function automatic void add_row(t_row w);
        rows = {rows, w};
    endfunction

    initial begin
        t_result r;
        sh_enable = '0;
        sh_rate = '0;
        for (int k = 0; k < 4; k++) begin
            sh_timing[k] = '0; sh_ticks[k] = '0; sh_due[k] = '0; sh_sched[k] = 0;
        end
        mismatches = 0;
        send_idle_pct = 6;
        recv_idle_pct = 74;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(typed_row(ptds_pkg::REQ_PEEK, 64'd0, ptds_pkg::ST_EMPTY));
        add_row(typed_row(ptds_pkg::REQ_COMPLETE, 64'h7FFF_FFFF_FFFF_FFFF, ptds_pkg::ST_EMPTY));
        add_row(typed_row(ptds_pkg::REQ_RESTART, 64'd0, ptds_pkg::ST_OK));
        add_row(cfg_row(ptds_pkg::CFG_ENABLE, 64'hF));
        add_row(cfg_row(ptds_pkg::CFG_RATE, 64'hA));
        add_row(typed_row(ptds_pkg::REQ_RESTART, 64'd0, ptds_pkg::ST_BADCFG));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0, 64'd10));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0 + 3'd1, 64'd3));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0 + 3'd2, {1'b0, TIME_TOP}));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0 + 3'd3, RATE_TOP));
        add_row(typed_row(ptds_pkg::REQ_RESTART, 64'd0, ptds_pkg::ST_OK));
        add_row(beat_row(ptds_pkg::REQ_PEEK, 64'h7FFF_FFFF_FFFF_FFFF));
        add_row(beat_row(ptds_pkg::REQ_PEEK, 64'h8000_0000_0000_0000));
        add_row(beat_row(REQ_UNKNOWN, 64'd10));
        add_row(beat_row(ptds_pkg::REQ_COMPLETE, 64'd5));
        add_row(beat_row(ptds_pkg::REQ_COMPLETE, 64'd20));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0 + 3'd3, RATE_TOP + 64'd1));
        add_row(beat_row(ptds_pkg::REQ_COMPLETE, 64'd0));
        add_row(beat_row(ptds_pkg::REQ_COMPLETE, 64'd0));
        add_row(cfg_row(CFG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(cfg_row(CFG_SPARE_HI, 64'h7FFF_FFFF_FFFF_FFFF));
        add_row(cfg_row(ptds_pkg::CFG_RATE, 64'h0));
        add_row(cfg_row(ptds_pkg::CFG_TIMING0 + 3'd2, 64'h4000_0000_0000_0001));
        add_row(typed_row(ptds_pkg::REQ_RESTART, 64'd0, ptds_pkg::ST_OK));
        add_row(beat_row(ptds_pkg::REQ_COMPLETE, 64'd0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].code, rows[i].data);
            end else begin
                send_beat(rows[i].code[1:0], rows[i].data, r);
                if (rows[i].typed && r != rows[i].want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: predicted st=%0d, table st=%0d",
                                 i, r.status, rows[i].want.status);
                end
            end
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                send_idle_pct = 74; recv_idle_pct = 6;
            end else if (n == 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if ($urandom_range(29) == 0) begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(7))
                        0: write_reg(ptds_pkg::CFG_ENABLE, 64'($urandom_range(15)));
                        1: write_reg(ptds_pkg::CFG_RATE, 64'($urandom_range(15)));
                        2: write_reg(3'($urandom_range(7, 6)), {$urandom, $urandom});
                        default: write_reg(ptds_pkg::CFG_TIMING0 + 3'($urandom_range(3)),
                                           pick_timing());
                    endcase
                end
                if ($urandom_range(3) != 0)
                    send_beat(ptds_pkg::REQ_RESTART, {$urandom, $urandom}, r);
            end
            send_beat(pick_request(), pick_target(), r);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("testbench: errors");
        $finish;
    end
endmodule
